// ----- rtl/byte_range_header_parser_assert.svh -----
// Assertion macros shared by the byte-range header parser modules.
// Depends on nothing; included by the modules that carry assertions.
`ifndef BYTE_RANGE_HEADER_PARSER_ASSERT_SVH
`define BYTE_RANGE_HEADER_PARSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BRHP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("brhp: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BRHP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("brhp: next-cycle check failed");

`endif

// ----- rtl/brhp_pkg.sv -----
// Shared types, constants and helper functions of the byte-range header parser.
// Depends on nothing; used by every module of the block.
package brhp_pkg;

   localparam int unsigned VAL_W       = 64;
   localparam int unsigned CHAR_W      = 8;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned PREFIX_LEN  = 5;
   localparam int unsigned PROG_W      = 3;

   localparam logic [PROG_W-1:0] PREFIX_DONE = PROG_W'(PREFIX_LEN);

   // Character codes.
   localparam logic [CHAR_W-1:0] CH_EQUALS = 8'h3D;
   localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
   localparam logic [CHAR_W-1:0] CH_DASH   = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
   localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
   localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
   localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;

   // Result codes.
   localparam logic KIND_RANGE      = 1'b0;
   localparam logic KIND_VERDICT    = 1'b1;
   localparam logic VERDICT_PRESENT = 1'b0;
   localparam logic VERDICT_INVALID = 1'b1;

   typedef enum logic [1:0] {
      HDR_PREFIX,
      HDR_RANGES,
      HDR_REJECTED
   } hdr_phase_type;

   typedef enum logic [1:0] {
      RNG_LEAD,
      RNG_START,
      RNG_END,
      RNG_TRAIL
   } rng_phase_type;

   // One closed header event handed from the front end to the back end.
   typedef struct packed {
      logic             has_range;
      logic [VAL_W-1:0] start_val;
      logic [VAL_W-1:0] end_val;
      logic             start_has;
      logic             end_has;
      logic             has_verdict;
      logic             hdr_ok;
   } brhp_entry_type;

   // Letters of the unit word, indexed by the number already matched.
   function automatic logic [CHAR_W-1:0] word_char(input logic [PROG_W-1:0] idx);
      logic [CHAR_W-1:0] c;
      case (idx)
         3'd0:    c = 8'h62;
         3'd1:    c = 8'h79;
         3'd2:    c = 8'h74;
         3'd3:    c = 8'h65;
         3'd4:    c = 8'h73;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // Space, tab, line feed, vertical tab, form feed and carriage return.
   function automatic logic is_ws(input logic [CHAR_W-1:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

endpackage

// ----- rtl/byte_range_header_parser.sv -----
// Top level of the byte-range header parser: resource size register, front
// end, event queue and back end. Depends on brhp_pkg and the brhp_* modules.
//
//   Channel   Direction  Handshake               Payload
//   req_      in         req_valid / req_stall   req_ch, req_last
//   rsp_      out        rsp_valid / rsp_stall   rsp_kind, rsp_first_byte, rsp_last_byte,
//                                                rsp_verdict, rsp_end_of_run
//   csr_      in         csr_write_en            csr_write_data (resource size)
//
// One character is taken every cycle while req_stall is low; the front end classifies it in
// the cycle it arrives. A range or verdict passes from the queue through the offset stage to
// the output register, each step waiting while the stage ahead is held by a stall; a verdict
// that follows a range of the same entry waits in the offset stage until the range has issued.
// The four-entry queue between front and back sets how far req_ runs ahead of a stalled rsp_.
// Synchronous reset clears all control state and the resource size; no clearing pass is needed.
// req_stall rises only while the queue is full.

module byte_range_header_parser (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [brhp_pkg::CHAR_W-1:0]  req_ch,
   input  logic                         req_last,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_kind,
   output logic [brhp_pkg::VAL_W-1:0]   rsp_first_byte,
   output logic [brhp_pkg::VAL_W-1:0]   rsp_last_byte,
   output logic                         rsp_verdict,
   output logic                         rsp_end_of_run,
   input  logic                         csr_write_en,
   input  logic [brhp_pkg::VAL_W-1:0]   csr_write_data
);

   logic [brhp_pkg::VAL_W-1:0]   resource_size_ff, resource_size_in;
   logic                         q_push, q_full, q_pop, q_head_valid;
   brhp_pkg::brhp_entry_type     q_push_entry, q_head_entry;

   // Resource size register.
   assign resource_size_in = csr_write_en ? csr_write_data : resource_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         resource_size_ff <= '0;
      end else begin
         resource_size_ff <= resource_size_in;
      end
   end

   brhp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_ch    (req_ch),
      .req_last  (req_last),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_entry   (q_push_entry)
   );

   brhp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_entry (q_head_entry)
   );

   brhp_back u_back (
      .clock          (clock),
      .reset          (reset),
      .size           (resource_size_ff),
      .head_valid     (q_head_valid),
      .head_entry     (q_head_entry),
      .pop            (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_first_byte (rsp_first_byte),
      .rsp_last_byte  (rsp_last_byte),
      .rsp_verdict    (rsp_verdict),
      .rsp_end_of_run (rsp_end_of_run)
   );

endmodule

// ----- rtl/brhp_front.sv -----
// Front end of the byte-range header parser: accepts characters, tracks the
// header and range state, and queues each well-formed closed range and each verdict.
// Depends on brhp_pkg.
`include "byte_range_header_parser_assert.svh"

module brhp_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [brhp_pkg::CHAR_W-1:0]  req_ch,
   input  logic                         req_last,
   input  logic                         q_full,
   output logic                         q_push,
   output brhp_pkg::brhp_entry_type     q_entry
);

   brhp_pkg::hdr_phase_type             hp_ff, hp_in, hp_post;
   logic [brhp_pkg::PROG_W-1:0]         pp_ff, pp_in, pp_post;
   brhp_pkg::rng_phase_type             rp_ff, rp_in, rp_post;
   logic [brhp_pkg::VAL_W-1:0]          sv_ff, sv_in, sv_post;
   logic [brhp_pkg::VAL_W-1:0]          ev_ff, ev_in, ev_post;
   logic                                sh_ff, sh_in, sh_post;
   logic                                eh_ff, eh_in, eh_post;
   logic                                brk_ff, brk_in, brk_post;
   logic                                comma_close;

   logic                                fire;
   logic                                ch_ws, ch_digit, ch_equals, ch_comma, ch_dash;
   logic [brhp_pkg::VAL_W-1:0]          acc_sel;
   logic [brhp_pkg::VAL_W+3:0]          acc_sum;
   logic [brhp_pkg::VAL_W-1:0]          acc_new;
   logic                                acc_ovf;
   logic                                cur_ok, post_ok;

   // A range can be kept only if unbroken, past its dash and holding a number.
   function automatic logic range_ok(input logic brk, input brhp_pkg::rng_phase_type rp,
                                     input logic sh, input logic eh);
      return !brk && ((rp == brhp_pkg::RNG_END) || (rp == brhp_pkg::RNG_TRAIL)) && (sh || eh);
   endfunction

   // The queue applies back-pressure straight to the request channel.
   assign req_stall = q_full;
   assign fire      = req_valid && !q_full;

   // Character classes.
   assign ch_ws     = brhp_pkg::is_ws(req_ch);
   assign ch_digit  = (req_ch >= brhp_pkg::CH_ZERO) && (req_ch <= brhp_pkg::CH_NINE);
   assign ch_equals = (req_ch == brhp_pkg::CH_EQUALS);
   assign ch_comma  = (req_ch == brhp_pkg::CH_COMMA);
   assign ch_dash   = (req_ch == brhp_pkg::CH_DASH);

   // Decimal accumulate: acc * 10 + digit, with any carry out of 64 bits as overflow.
   assign acc_sel = (rp_ff == brhp_pkg::RNG_END) ? ev_ff : sv_ff;
   assign acc_sum = ({4'b0, acc_sel} << 3) + ({4'b0, acc_sel} << 1)
                  + {{(brhp_pkg::VAL_W){1'b0}}, req_ch[3:0]};
   assign acc_new = acc_sum[brhp_pkg::VAL_W-1:0];
   assign acc_ovf = |acc_sum[brhp_pkg::VAL_W+3:brhp_pkg::VAL_W];

   // Next state: effect of the character on the header and range state.
   always_comb begin : post_calc
      hp_post     = hp_ff;
      pp_post     = pp_ff;
      rp_post     = rp_ff;
      sv_post     = sv_ff;
      ev_post     = ev_ff;
      sh_post     = sh_ff;
      eh_post     = eh_ff;
      brk_post    = brk_ff;
      comma_close = 1'b0;
      case (hp_ff)
         brhp_pkg::HDR_PREFIX: begin
            if (ch_equals) begin
               hp_post = (pp_ff == brhp_pkg::PREFIX_DONE) ? brhp_pkg::HDR_RANGES
                                                         : brhp_pkg::HDR_REJECTED;
            end else if (ch_ws) begin
               if (pp_ff != '0 && pp_ff != brhp_pkg::PREFIX_DONE) begin
                  hp_post = brhp_pkg::HDR_REJECTED;
               end
            end else if (pp_ff != brhp_pkg::PREFIX_DONE &&
                         req_ch == brhp_pkg::word_char(pp_ff)) begin
               pp_post = pp_ff + 1'b1;
            end else begin
               hp_post = brhp_pkg::HDR_REJECTED;
            end
         end
         brhp_pkg::HDR_RANGES: begin
            if (ch_comma) begin
               comma_close = 1'b1;
            end else begin
               case (rp_ff)
                  brhp_pkg::RNG_LEAD: begin
                     if (ch_ws) begin
                        rp_post = brhp_pkg::RNG_LEAD;
                     end else if (ch_digit) begin
                        rp_post = brhp_pkg::RNG_START;
                        sh_post = 1'b1;
                        if (acc_ovf) brk_post = 1'b1;
                        else sv_post = acc_new;
                     end else if (ch_dash) begin
                        rp_post = brhp_pkg::RNG_END;
                     end else begin
                        brk_post = 1'b1;
                        rp_post  = brhp_pkg::RNG_TRAIL;
                     end
                  end
                  brhp_pkg::RNG_START: begin
                     if (ch_digit) begin
                        sh_post = 1'b1;
                        if (acc_ovf) brk_post = 1'b1;
                        else sv_post = acc_new;
                     end else if (ch_dash) begin
                        rp_post = brhp_pkg::RNG_END;
                     end else begin
                        brk_post = 1'b1;
                        rp_post  = brhp_pkg::RNG_TRAIL;
                     end
                  end
                  brhp_pkg::RNG_END: begin
                     if (ch_digit) begin
                        eh_post = 1'b1;
                        if (acc_ovf) brk_post = 1'b1;
                        else ev_post = acc_new;
                     end else if (ch_ws) begin
                        rp_post = brhp_pkg::RNG_TRAIL;
                     end else begin
                        brk_post = 1'b1;
                        rp_post  = brhp_pkg::RNG_TRAIL;
                     end
                  end
                  default: begin
                     if (!ch_ws) brk_post = 1'b1;
                  end
               endcase
            end
         end
         default: begin
            hp_post = hp_ff;
         end
      endcase
   end

   // Register update: the last character clears the header, a comma the range.
   always_comb begin : state_next
      hp_in  = hp_ff;
      pp_in  = pp_ff;
      rp_in  = rp_ff;
      sv_in  = sv_ff;
      ev_in  = ev_ff;
      sh_in  = sh_ff;
      eh_in  = eh_ff;
      brk_in = brk_ff;
      if (fire) begin
         if (req_last || comma_close) begin
            hp_in  = req_last ? brhp_pkg::HDR_PREFIX : hp_post;
            pp_in  = req_last ? '0 : pp_post;
            rp_in  = brhp_pkg::RNG_LEAD;
            sv_in  = '0;
            ev_in  = '0;
            sh_in  = 1'b0;
            eh_in  = 1'b0;
            brk_in = 1'b0;
         end else begin
            hp_in  = hp_post;
            pp_in  = pp_post;
            rp_in  = rp_post;
            sv_in  = sv_post;
            ev_in  = ev_post;
            sh_in  = sh_post;
            eh_in  = eh_post;
            brk_in = brk_post;
         end
      end
   end

   // Outputs: a comma closes the range as it stood; the last character closes
   // the range as it stands after that character, and brings the verdict.
   always_comb begin : queue_out
      cur_ok  = range_ok(brk_ff, rp_ff, sh_ff, eh_ff);
      post_ok = range_ok(brk_post, rp_post, sh_post, eh_post);
      q_entry.has_range   = comma_close ? cur_ok
                          : (req_last && hp_post == brhp_pkg::HDR_RANGES && post_ok);
      q_entry.start_val   = comma_close ? sv_ff : sv_post;
      q_entry.end_val     = comma_close ? ev_ff : ev_post;
      q_entry.start_has   = comma_close ? sh_ff : sh_post;
      q_entry.end_has     = comma_close ? eh_ff : eh_post;
      q_entry.has_verdict = req_last;
      q_entry.hdr_ok      = (hp_post == brhp_pkg::HDR_RANGES);
      q_push = fire && (q_entry.has_range || req_last);
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         hp_ff  <= brhp_pkg::HDR_PREFIX;
         pp_ff  <= '0;
         rp_ff  <= brhp_pkg::RNG_LEAD;
         sv_ff  <= '0;
         ev_ff  <= '0;
         sh_ff  <= 1'b0;
         eh_ff  <= 1'b0;
         brk_ff <= 1'b0;
      end else begin
         hp_ff  <= hp_in;
         pp_ff  <= pp_in;
         rp_ff  <= rp_in;
         sv_ff  <= sv_in;
         ev_ff  <= ev_in;
         sh_ff  <= sh_in;
         eh_ff  <= eh_in;
         brk_ff <= brk_in;
      end
   end

   // Prefix progress never passes the full word, and ranges need the full word.
   `BRHP_ASSERT_NOW(a_prog_bound, clock, reset, 1'b1, pp_ff <= brhp_pkg::PREFIX_DONE)
   `BRHP_ASSERT_NOW(a_ranges_after_word, clock, reset, hp_ff == brhp_pkg::HDR_RANGES, pp_ff == brhp_pkg::PREFIX_DONE)

endmodule

// ----- rtl/brhp_queue.sv -----
// Short queue of closed header events between the front and back ends.
// Depends on brhp_pkg.
`include "byte_range_header_parser_assert.svh"

module brhp_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  brhp_pkg::brhp_entry_type  push_entry,
   output logic                      full,
   input  logic                      pop,
   output logic                      head_valid,
   output brhp_pkg::brhp_entry_type  head_entry
);

   brhp_pkg::brhp_entry_type          store_ff [brhp_pkg::QUEUE_DEPTH];
   logic [brhp_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [brhp_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [brhp_pkg::QCNT_W-1:0]       cnt_ff, cnt_in;

   assign full       = (cnt_ff == brhp_pkg::QCNT_W'(brhp_pkg::QUEUE_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_entry = store_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == brhp_pkg::QPTR_W'(brhp_pkg::QUEUE_DEPTH - 1))
                   ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == brhp_pkg::QPTR_W'(brhp_pkg::QUEUE_DEPTH - 1))
                   ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      else if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) store_ff[wr_ptr_ff] <= push_entry;
   end

   // The front end must never write a full queue, nor the back end read an empty one.
   `BRHP_ASSERT_NOW(a_no_overflow, clock, reset, push, !full)
   `BRHP_ASSERT_NOW(a_pop_nonempty, clock, reset, pop, cnt_ff != '0)
   `BRHP_ASSERT_NOW(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= brhp_pkg::QCNT_W'(brhp_pkg::QUEUE_DEPTH))

endmodule

// ----- rtl/brhp_back.sv -----
// Back end of the byte-range header parser: works out offsets against the
// resource size, drops empty ranges, and issues ranges and verdicts.
// Depends on brhp_pkg.
`include "byte_range_header_parser_assert.svh"

module brhp_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [brhp_pkg::VAL_W-1:0]   size,
   input  logic                         head_valid,
   input  brhp_pkg::brhp_entry_type     head_entry,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_kind,
   output logic [brhp_pkg::VAL_W-1:0]   rsp_first_byte,
   output logic [brhp_pkg::VAL_W-1:0]   rsp_last_byte,
   output logic                         rsp_verdict,
   output logic                         rsp_end_of_run
);

   // Offset stage.
   logic                                s1_valid_ff, s1_valid_in;
   logic                                s1_has_range_ff, s1_has_verdict_ff, s1_hdr_ok_ff;
   logic [brhp_pkg::VAL_W-1:0]          s1_start_ff, s1_end_ff, s1_lim_ff;
   logic                                range_done_ff, range_done_in;
   logic                                kept_ff, kept_in;

   // Output register.
   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                rsp_kind_ff, rsp_verdict_ff, rsp_end_of_run_ff;
   logic [brhp_pkg::VAL_W-1:0]          rsp_first_byte_ff, rsp_last_byte_ff;

   logic                                out_free, keep, emit_range, emit_verdict, s1_done;
   logic [brhp_pkg::VAL_W-1:0]          end_clamp, lim_new, start_new, end_new;

   // Offsets of a queued range; all arithmetic wraps at 64 bits.
   assign lim_new   = size - 1'b1;
   assign start_new = head_entry.start_has ? head_entry.start_val : size - head_entry.end_val;
   assign end_new   = (head_entry.start_has && head_entry.end_has) ? head_entry.end_val
                                                                  : lim_new;

   // Clamp the end and keep the range only if it is not empty.
   assign end_clamp = (s1_end_ff > s1_lim_ff) ? s1_lim_ff : s1_end_ff;
   assign keep      = s1_has_range_ff && (s1_start_ff <= s1_end_ff) && (s1_start_ff <= s1_lim_ff);

   // Issue sequencing: a kept range goes first, the verdict of the same entry after it.
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign emit_range   = s1_valid_ff && out_free && keep && !range_done_ff;
   assign emit_verdict = s1_valid_ff && out_free && s1_has_verdict_ff && !(keep && !range_done_ff);
   assign s1_done      = s1_valid_ff && out_free && !(emit_range && s1_has_verdict_ff);
   assign pop          = head_valid && (!s1_valid_ff || s1_done);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (pop) s1_valid_in = 1'b1;
      else if (s1_done) s1_valid_in = 1'b0;

      range_done_in = range_done_ff;
      if (emit_range && s1_has_verdict_ff) range_done_in = 1'b1;
      else if (s1_done) range_done_in = 1'b0;

      kept_in = kept_ff;
      if (emit_range) kept_in = 1'b1;
      else if (emit_verdict) kept_in = 1'b0;

      rsp_valid_in = rsp_valid_ff;
      if (emit_range || emit_verdict) rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         range_done_ff <= 1'b0;
         kept_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         range_done_ff <= range_done_in;
         kept_ff       <= kept_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Offset stage payload.
   always_ff @(posedge clock) begin
      if (pop) begin
         s1_has_range_ff   <= head_entry.has_range;
         s1_has_verdict_ff <= head_entry.has_verdict;
         s1_hdr_ok_ff      <= head_entry.hdr_ok;
         s1_start_ff       <= start_new;
         s1_end_ff         <= end_new;
         s1_lim_ff         <= lim_new;
      end
   end

   // Output payload; it only changes when the slot is free, so a stalled transaction holds.
   always_ff @(posedge clock) begin
      if (emit_range) begin
         rsp_kind_ff       <= brhp_pkg::KIND_RANGE;
         rsp_first_byte_ff <= s1_start_ff;
         rsp_last_byte_ff  <= end_clamp;
         rsp_verdict_ff    <= brhp_pkg::VERDICT_PRESENT;
         rsp_end_of_run_ff <= 1'b0;
      end else if (emit_verdict) begin
         rsp_kind_ff       <= brhp_pkg::KIND_VERDICT;
         rsp_first_byte_ff <= '0;
         rsp_last_byte_ff  <= '0;
         rsp_verdict_ff    <= (s1_hdr_ok_ff && kept_ff) ? brhp_pkg::VERDICT_PRESENT
                                                        : brhp_pkg::VERDICT_INVALID;
         rsp_end_of_run_ff <= 1'b1;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_first_byte = rsp_first_byte_ff;
   assign rsp_last_byte  = rsp_last_byte_ff;
   assign rsp_verdict    = rsp_verdict_ff;
   assign rsp_end_of_run = rsp_end_of_run_ff;

   // A half-issued entry stays in the stage; ranges are non-empty; the kept flag restarts per header.
   `BRHP_ASSERT_NOW(a_done_needs_entry, clock, reset, range_done_ff, s1_valid_ff && s1_has_verdict_ff)
   `BRHP_ASSERT_NOW(a_range_fields, clock, reset, rsp_valid_ff && rsp_kind_ff == brhp_pkg::KIND_RANGE, !rsp_end_of_run_ff && rsp_first_byte_ff <= rsp_last_byte_ff)
   `BRHP_ASSERT_NEXT(a_kept_cleared, clock, reset, emit_verdict, !kept_ff)

endmodule

// ----- verif/byte_range_header_parser_tb.sv -----
// Self-checking testbench for the byte-range header parser: directed and random headers.
// Depends on brhp_pkg and byte_range_header_parser; it predicts every range and verdict
// and compares each one with the result port.
module byte_range_header_parser_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          LIMIT_CYCLES  = 400000;
   localparam int          SETTLE_CYCLES = 12;
   localparam int          HOLD_CYCLES   = 120;
   localparam logic [39:0] UNIT_WORD     = "bytes";
   localparam logic [63:0] ALL_ONES      = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct {
      logic        kind;
      logic [63:0] first_byte;
      logic [63:0] last_byte;
      logic        verdict;
      logic        end_of_run;
   } parse_result_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_ch;
   logic        req_last;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_kind;
   logic [63:0] rsp_first_byte;
   logic [63:0] rsp_last_byte;
   logic        rsp_verdict;
   logic        rsp_end_of_run;
   logic        csr_write_en;
   logic [63:0] csr_write_data;

   // Predictor state, a copy of what the block should hold.
   brhp_pkg::hdr_phase_type hdr_phase;
   brhp_pkg::rng_phase_type rng_phase;
   logic [2:0]              word_pos;
   logic [63:0]             size_reg;
   logic [63:0]             start_acc;
   logic [63:0]             end_acc;
   bit                      start_seen;
   bit                      end_seen;
   bit                      rng_bad;
   bit                      kept_any;

   parse_result_type pending_results[$];
   logic [7:0]       hdr_text[$];

   int cycle_count      = 0;
   int hold_until       = 0;
   int sender_idle_pct  = 0;
   int recv_stall_pct   = 0;
   int mismatch_count   = 0;
   int headers_sent     = 0;
   int chars_sent       = 0;
   int sizes_used       = 0;
   int ranges_checked   = 0;
   int verdicts_checked = 0;

   byte_range_header_parser dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_ch         (req_ch),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_first_byte (rsp_first_byte),
      .rsp_last_byte  (rsp_last_byte),
      .rsp_verdict    (rsp_verdict),
      .rsp_end_of_run (rsp_end_of_run),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Cycle counter and watchdog.
   initial begin
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, pending_results.size());
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // Result side stalls: a long hold-off when one is asked for, otherwise at random.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (cycle_count < hold_until) begin
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------------

   function automatic bit is_blank(logic [7:0] c);
      return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
   endfunction

   function automatic void push_result(logic kind, logic [63:0] first_byte,
                                       logic [63:0] last_byte, logic verdict,
                                       logic end_of_run);
      parse_result_type r;
      r.kind       = kind;
      r.first_byte = first_byte;
      r.last_byte  = last_byte;
      r.verdict    = verdict;
      r.end_of_run = end_of_run;
      pending_results = {pending_results, r};
   endfunction

   function automatic void clear_range();
      rng_phase  = brhp_pkg::RNG_LEAD;
      start_acc  = '0;
      end_acc    = '0;
      start_seen = 1'b0;
      end_seen   = 1'b0;
      rng_bad    = 1'b0;
   endfunction

   function automatic void clear_header();
      hdr_phase = brhp_pkg::HDR_PREFIX;
      word_pos  = '0;
      kept_any  = 1'b0;
      clear_range();
   endfunction

   // Decimal accumulate; a digit that would overflow 64 bits spoils the range.
   function automatic void add_digit(bit to_end, logic [7:0] c);
      logic [63:0] d;
      logic [63:0] acc;
      d   = {56'd0, c - brhp_pkg::CH_ZERO};
      acc = to_end ? end_acc : start_acc;
      if (acc > (ALL_ONES - d) / 64'd10) begin
         rng_bad = 1'b1;
      end else begin
         acc = acc * 64'd10 + d;
      end
      if (to_end) begin
         end_acc  = acc;
         end_seen = 1'b1;
      end else begin
         start_acc  = acc;
         start_seen = 1'b1;
      end
   endfunction

   // Close the current range and expect it if it survives the size clamp.
   function automatic void close_range();
      logic [63:0] lim;
      logic [63:0] s;
      logic [63:0] e;
      lim = size_reg - 64'd1;
      if (!rng_bad && (rng_phase == brhp_pkg::RNG_END || rng_phase == brhp_pkg::RNG_TRAIL) &&
          (start_seen || end_seen)) begin
         if (!start_seen) begin
            s = size_reg - end_acc;
            e = lim;
         end else if (!end_seen) begin
            s = start_acc;
            e = lim;
         end else begin
            s = start_acc;
            e = end_acc;
         end
         if (e > lim) e = lim;
         if (s <= e) begin
            push_result(brhp_pkg::KIND_RANGE, s, e, brhp_pkg::VERDICT_PRESENT, 1'b0);
            kept_any = 1'b1;
         end
      end
      clear_range();
   endfunction

   function automatic void range_char(logic [7:0] c);
      bit digit;
      digit = (c >= brhp_pkg::CH_ZERO) && (c <= brhp_pkg::CH_NINE);
      case (rng_phase)
         brhp_pkg::RNG_LEAD: begin
            if (digit) begin
               rng_phase = brhp_pkg::RNG_START;
               add_digit(1'b0, c);
            end else if (c == brhp_pkg::CH_DASH) begin
               rng_phase = brhp_pkg::RNG_END;
            end else if (!is_blank(c)) begin
               rng_bad   = 1'b1;
               rng_phase = brhp_pkg::RNG_TRAIL;
            end
         end
         brhp_pkg::RNG_START: begin
            if (digit) begin
               add_digit(1'b0, c);
            end else if (c == brhp_pkg::CH_DASH) begin
               rng_phase = brhp_pkg::RNG_END;
            end else begin
               rng_bad   = 1'b1;
               rng_phase = brhp_pkg::RNG_TRAIL;
            end
         end
         brhp_pkg::RNG_END: begin
            if (digit) begin
               add_digit(1'b1, c);
            end else begin
               if (!is_blank(c)) rng_bad = 1'b1;
               rng_phase = brhp_pkg::RNG_TRAIL;
            end
         end
         default: begin
            if (!is_blank(c)) rng_bad = 1'b1;
         end
      endcase
   endfunction

   // Work out the results that one accepted character causes.
   function automatic void predict_char(logic [7:0] c, bit last);
      if (hdr_phase == brhp_pkg::HDR_PREFIX) begin
         if (c == brhp_pkg::CH_EQUALS) begin
            hdr_phase = (word_pos == 3'd5) ? brhp_pkg::HDR_RANGES : brhp_pkg::HDR_REJECTED;
         end else if (is_blank(c)) begin
            if (word_pos != 3'd0 && word_pos != 3'd5) hdr_phase = brhp_pkg::HDR_REJECTED;
         end else if (word_pos < 3'd5 && c == UNIT_WORD[8 * (4 - int'(word_pos)) +: 8]) begin
            word_pos++;
         end else begin
            hdr_phase = brhp_pkg::HDR_REJECTED;
         end
      end else if (hdr_phase == brhp_pkg::HDR_RANGES) begin
         if (c == brhp_pkg::CH_COMMA) close_range();
         else range_char(c);
      end
      if (last) begin
         if (hdr_phase == brhp_pkg::HDR_RANGES) close_range();
         push_result(brhp_pkg::KIND_VERDICT, '0, '0,
                     (hdr_phase == brhp_pkg::HDR_RANGES && kept_any)
                        ? brhp_pkg::VERDICT_PRESENT : brhp_pkg::VERDICT_INVALID,
                     1'b1);
         clear_header();
      end
   endfunction

   // ---------------------------------------------------------------------------------
   // Result checking
   // ---------------------------------------------------------------------------------

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("Mismatch at cycle %0d: %s, got %0h, expected %0h", cycle_count, what, got,
               want);
      mismatch_count++;
   endtask

   // Every accepted result transaction is compared with the oldest expectation.
   always @(posedge clock) begin
      parse_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with nothing expected", {63'd0, rsp_kind}, '0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_kind !== want.kind)
               report_mismatch("kind", {63'd0, rsp_kind}, {63'd0, want.kind});
            if (rsp_first_byte !== want.first_byte)
               report_mismatch("first_byte", rsp_first_byte, want.first_byte);
            if (rsp_last_byte !== want.last_byte)
               report_mismatch("last_byte", rsp_last_byte, want.last_byte);
            if (rsp_verdict !== want.verdict)
               report_mismatch("verdict", {63'd0, rsp_verdict}, {63'd0, want.verdict});
            if (rsp_end_of_run !== want.end_of_run)
               report_mismatch("end_of_run", {63'd0, rsp_end_of_run},
                               {63'd0, want.end_of_run});
            if (want.kind == brhp_pkg::KIND_VERDICT) verdicts_checked++;
            else ranges_checked++;
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------------

   // Offer one character transaction and wait until it is taken.
   task automatic send_char(logic [7:0] c, bit last);
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_ch    <= c;
      req_last  <= last;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      predict_char(c, last);
      chars_sent++;
   endtask

   task automatic send_header();
      for (int i = 0; i < hdr_text.size(); i++) begin
         send_char(hdr_text[i], i == hdr_text.size() - 1);
      end
      headers_sent++;
   endtask

   function automatic void put_char(logic [7:0] c);
      hdr_text = {hdr_text, c};
   endfunction

   function automatic void put_text(string s);
      for (int i = 0; i < s.len(); i++) put_char(s[i]);
   endfunction

   task automatic send_text(string s);
      hdr_text = {};
      put_text(s);
      send_header();
   endtask

   // The sender pauses until every result is back and the pipeline has settled.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_resource_size(logic [63:0] value);
      wait_drained();
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_en   <= 1'b0;
      size_reg = value;
      sizes_used++;
   endtask

   function automatic logic [7:0] blank_char();
      int pick;
      pick = $urandom_range(0, 5);
      return (pick == 0) ? 8'h20 : 8'(8 + pick);
   endfunction

   function automatic void put_blanks(int most);
      int n;
      n = $urandom_range(0, most);
      repeat (n) put_char(blank_char());
   endfunction

   function automatic void put_number(logic [63:0] v);
      put_text($sformatf("%0d", v));
   endfunction

   // Values that land near zero, near the resource size or a fraction of it, near the 64-bit limit, or anywhere.
   function automatic logic [63:0] pick_value();
      logic [63:0] v;
      case ($urandom_range(0, 5))
         0:       v = 64'($urandom_range(0, 20));
         1:       v = size_reg + 64'($urandom_range(0, 4)) - 64'd2;
         2:       v = {$urandom, $urandom};
         3:       v = ALL_ONES - 64'($urandom_range(0, 3));
         4:       v = 64'($urandom_range(0, 2000));
         default: v = size_reg >> $urandom_range(0, 8);
      endcase
      return v;
   endfunction

   // A number at or past the 64-bit limit.
   function automatic void put_big_number();
      case ($urandom_range(0, 2))
         0:       put_text("18446744073709551615");
         1:       put_text("18446744073709551616");
         default: put_text($sformatf("%0d%0d", ALL_ONES, $urandom_range(0, 9)));
      endcase
   endfunction

   // One range, mostly well formed, sometimes spoilt in one of several ways.
   function automatic void put_range();
      logic [63:0] a;
      logic [63:0] b;
      a = pick_value();
      b = pick_value();
      put_blanks(1);
      case ($urandom_range(0, 11))
         0, 1, 2, 3: begin
            put_number(a);
            put_char(brhp_pkg::CH_DASH);
            put_number(b);
         end
         4, 5: begin
            put_number(a);
            put_char(brhp_pkg::CH_DASH);
         end
         6, 7: begin
            put_char(brhp_pkg::CH_DASH);
            put_number(b);
         end
         8: begin
            put_number(a);
            if ($urandom_range(0, 1)) put_char(8'($urandom_range(0, 255)));
            put_char(brhp_pkg::CH_DASH);
            put_number(b);
            put_char(8'($urandom_range(0, 255)));
         end
         9: begin
            if ($urandom_range(0, 1)) begin
               put_big_number();
               put_char(brhp_pkg::CH_DASH);
            end else begin
               put_char(brhp_pkg::CH_DASH);
               put_big_number();
            end
         end
         10: begin
            case ($urandom_range(0, 5))
               0: ;
               1: put_char(brhp_pkg::CH_DASH);
               2: put_number(a);
               3: begin
                  put_number(a);
                  put_text("--");
                  put_number(b);
               end
               4: begin
                  put_number(a);
                  put_char(blank_char());
                  put_number(b);
                  put_char(brhp_pkg::CH_DASH);
               end
               default: begin
                  put_number(a);
                  put_char(brhp_pkg::CH_DASH);
                  put_number(b);
                  put_char(blank_char());
                  put_number(b);
               end
            endcase
         end
         default: begin
            put_text("000");
            put_number(a);
            put_char(brhp_pkg::CH_DASH);
            put_text("0");
            put_number(b);
         end
      endcase
      put_blanks(1);
   endfunction

   // Mostly well-formed headers with random ranges; the rest break the prefix or are noise.
   function automatic void build_random_header();
      int sel;
      int n;
      int pos;
      hdr_text = {};
      sel = $urandom_range(0, 99);
      if (sel < 82) begin
         put_blanks(2);
         put_text("bytes");
         put_blanks(2);
         put_char(brhp_pkg::CH_EQUALS);
         n = $urandom_range(1, 4);
         for (int i = 0; i < n; i++) begin
            if (i > 0) put_char(brhp_pkg::CH_COMMA);
            put_range();
         end
         if ($urandom_range(0, 9) == 0) put_char(brhp_pkg::CH_COMMA);
      end else if (sel < 92) begin
         put_blanks(1);
         pos = $urandom_range(0, 5);
         for (int i = 0; i < 5; i++) begin
            if (i != pos) begin
               put_char(UNIT_WORD[8 * (4 - i) +: 8]);
            end else begin
               case ($urandom_range(0, 3))
                  0:       put_char(blank_char());
                  1:       put_char(UNIT_WORD[8 * (4 - i) +: 8] ^ 8'h20);
                  2:       put_char(8'($urandom_range(0, 255)));
                  default: put_char(brhp_pkg::CH_EQUALS);
               endcase
            end
         end
         if (pos == 5) begin
            put_blanks(1);
            if ($urandom_range(0, 1)) put_range();
         end else begin
            put_char(brhp_pkg::CH_EQUALS);
            put_range();
         end
      end else begin
         n = $urandom_range(1, 10);
         repeat (n) put_char(8'($urandom_range(0, 255)));
      end
   endfunction

   task automatic run_random_part(logic [63:0] size_value, int char_goal);
      int goal;
      set_resource_size(size_value);
      goal = chars_sent + char_goal;
      while (chars_sent < goal) begin
         build_random_header();
         send_header();
      end
   endtask

   task automatic run_random_phase(int send_pct, int recv_pct, logic [63:0] size_a,
                                   logic [63:0] size_b, int char_goal);
      wait_drained();
      sender_idle_pct = send_pct;
      recv_stall_pct  = recv_pct;
      run_random_part(size_a, char_goal);
      run_random_part(size_b, char_goal);
   endtask

   // ---------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------

   // Prefix handling: surrounding whitespace, wrong case, short word, inner blank, no '='.
   task automatic test_prefix_rules();
      set_resource_size(64'd1000);
      send_text("bytes=0-9");
      send_text(" \tbytes \r=5-");
      send_text("Bytes=0-1");
      send_text("byte=0-1");
      send_text("by tes=1-2");
      send_text("bytes");
      send_text("=");
      // Vertical tab and form feed around the unit word, and a line feed at the end.
      hdr_text = {};
      put_char(8'h0B);
      put_text("bytes");
      put_char(8'h0C);
      put_text("=1-2");
      put_char(8'h0A);
      send_header();
   endtask

   // The three range forms, clamping, and ranges dropped because start exceeds end.
   task automatic test_range_forms();
      send_text("bytes=0-499,500-,-100,900-5000");
      send_text("bytes=7-3,-0,1000-");
   endtask

   // Stray characters, inner blanks, empty pieces, overflow and a trailing comma.
   task automatic test_broken_ranges();
      send_text("bytes=1-2x, 3 -4,5-6-7,8=9,,-,12,-3 4");
      send_text("bytes=18446744073709551616-,0-18446744073709551615");
      send_text("bytes=4-5,");
   endtask

   // Wrap-around of the size arithmetic at the extremes of the register.
   task automatic test_size_extremes();
      set_resource_size(64'd0);
      send_text("bytes=0-,-5,3-18446744073709551615");
      set_resource_size(ALL_ONES);
      send_text("bytes=-18446744073709551615,0-");
      set_resource_size(64'd1);
      send_text("bytes=0-0,1-,-1,-2");
   endtask

   // A long hold on the result side fills the internal queue and stalls the input.
   task automatic test_result_backpressure();
      set_resource_size(64'd1000);
      sender_idle_pct = 0;
      recv_stall_pct  = 0;
      hold_until      = cycle_count + HOLD_CYCLES;
      hdr_text = {};
      put_text("bytes=");
      for (int i = 0; i < 16; i++) begin
         if (i > 0) put_char(brhp_pkg::CH_COMMA);
         put_number(64'(2 * i));
         put_char(brhp_pkg::CH_DASH);
         put_number(64'(2 * i + 1));
      end
      send_header();
      send_text("bytes=1-1,2-2,3-3");
      wait_drained();
   endtask

   task automatic test_random_traffic();
      run_random_phase(0, 0, 64'd1000, ALL_ONES, 75);
      run_random_phase(76, 0, 64'd0, 64'd1, 75);
      run_random_phase(0, 76, {$urandom, $urandom}, 64'h8000_0000_0000_0000, 75);
      run_random_phase(14, 14, 64'($urandom_range(1, 50)), 64'd999999, 75);
   endtask

   // Reset, then the tests in turn, then the verdict of the run.
   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_ch         = '0;
      req_last       = 1'b0;
      csr_write_en   = 1'b0;
      csr_write_data = '0;
      size_reg       = '0;
      clear_header();
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      test_prefix_rules();
      test_range_forms();
      test_broken_ranges();
      test_size_extremes();
      test_result_backpressure();
      test_random_traffic();
      wait_drained();

      $display("Run covered %0d headers (%0d characters) over %0d resource sizes,",
               headers_sent, chars_sent, sizes_used);
      $display("with %0d ranges and %0d verdicts checked and %0d mismatches.",
               ranges_checked, verdicts_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
